FILE: hdl/bdl_pkg.sv
// Package for the bounded deque list unit: opcodes, status codes, defaults
// and the control word passed from the pointer logic to the top level.
// No dependencies.
package bdl_pkg;

  localparam int BDL_CAPACITY   = 128;
  localparam int BDL_ELEM_WIDTH = 32;

  typedef enum logic [2:0] {
    OP_PUSH_FRONT = 3'd0,
    OP_PUSH_BACK  = 3'd1,
    OP_POP_FRONT  = 3'd2,
    OP_DROP_N     = 3'd3,
    OP_TAKE_N     = 3'd4,
    OP_READ_INDEX = 3'd5
  } op_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2,
    ST_RANGE = 2'd3
  } status_t;

  // control word for one accepted operation
  typedef struct packed {
    logic    wr_en;    // store write of the pushed word
    logic    rd_zero;  // result data forced to zero
    status_t status;
  } ctl_t;

endpackage

FILE: hdl/bdl_ctrl.sv
// Front pointer and element count of the deque, plus the per-operation
// decode that yields store addresses and the control word.
// Depends on bdl_pkg.
module bdl_ctrl
  import bdl_pkg::*;
#(
  parameter int CAPACITY = BDL_CAPACITY,
  localparam int PTR_W = $clog2(CAPACITY),
  localparam int CNT_W = $clog2(CAPACITY + 1)
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             accept,
  input  logic [2:0]       opcode,
  input  logic [CNT_W-1:0] count,
  output logic [PTR_W-1:0] waddr,
  output logic [PTR_W-1:0] raddr,
  output logic [CNT_W-1:0] len_nxt,
  output ctl_t             ctl
);

  localparam logic [CNT_W:0]   CAP_S = (CNT_W + 1)'(CAPACITY);
  localparam logic [CNT_W-1:0] CAP_C = CNT_W'(CAPACITY);
  localparam logic [CNT_W-1:0] ONE_C = CNT_W'(1);

  logic [PTR_W-1:0] fp_r, fp_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;

  logic [PTR_W-1:0] fp_dec, fp_inc, fp_drop, addr_back, addr_idx;
  logic [CNT_W-1:0] drop_k;
  logic             full, empty, is_read;
  status_t          status;
  logic             we;
  op_t              op;

  // base + off modulo CAPACITY, valid while off <= CAPACITY
  function automatic logic [PTR_W-1:0] wrap(input logic [PTR_W-1:0] base,
                                            input logic [CNT_W-1:0] off);
    logic [CNT_W:0] s;
    s = (CNT_W + 1)'(base) + (CNT_W + 1)'(off);
    if (s >= CAP_S) s = s - CAP_S;
    return s[PTR_W-1:0];
  endfunction

  assign full      = (cnt_r == CAP_C);
  assign empty     = (cnt_r == '0);
  assign drop_k    = (count < cnt_r) ? count : cnt_r;
  assign fp_dec    = wrap(fp_r, CAP_C - ONE_C);
  assign fp_inc    = wrap(fp_r, ONE_C);
  assign fp_drop   = wrap(fp_r, drop_k);
  assign addr_back = wrap(fp_r, cnt_r);
  assign addr_idx  = wrap(fp_r, count);
  assign op        = op_t'(opcode);

  always_comb begin
    fp_nxt  = fp_r;
    cnt_nxt = cnt_r;
    we      = 1'b0;
    waddr   = addr_back;
    status  = ST_OK;
    is_read = 1'b0;
    case (op)
      OP_PUSH_FRONT: begin
        if (full) begin
          status = ST_FULL;
        end else begin
          fp_nxt  = fp_dec;
          waddr   = fp_dec;
          we      = 1'b1;
          cnt_nxt = cnt_r + ONE_C;
        end
      end
      OP_PUSH_BACK: begin
        if (full) begin
          status = ST_FULL;
        end else begin
          we      = 1'b1;
          cnt_nxt = cnt_r + ONE_C;
        end
      end
      OP_POP_FRONT: begin
        if (empty) begin
          status = ST_EMPTY;
        end else begin
          fp_nxt  = fp_inc;
          cnt_nxt = cnt_r - ONE_C;
        end
      end
      OP_DROP_N: begin
        fp_nxt  = fp_drop;
        cnt_nxt = cnt_r - drop_k;
      end
      OP_TAKE_N: begin
        if (cnt_r > count) cnt_nxt = count;
      end
      OP_READ_INDEX: begin
        is_read = 1'b1;
        if (count >= cnt_r) status = ST_RANGE;
      end
      default: ;
    endcase
  end

  // a good read looks up the indexed word, everything else the new front
  assign raddr       = (is_read && status == ST_OK) ? addr_idx : fp_nxt;
  assign len_nxt     = cnt_nxt;
  assign ctl.wr_en   = we;
  assign ctl.status  = status;
  assign ctl.rd_zero = (status == ST_RANGE) || (cnt_nxt == '0);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fp_r  <= '0;
      cnt_r <= '0;
    end else if (accept) begin
      fp_r  <= fp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

endmodule

FILE: hdl/bdl_store.sv
// Element store of the deque: one write and one registered read per cycle
// with accept high; the written word is bypassed if both hit the same entry.
// Depends on bdl_pkg.
module bdl_store
  import bdl_pkg::*;
#(
  parameter int CAPACITY   = BDL_CAPACITY,
  parameter int ELEM_WIDTH = BDL_ELEM_WIDTH,
  localparam int PTR_W = $clog2(CAPACITY)
) (
  input  logic                  clk,
  input  logic                  accept,
  input  logic                  we,
  input  logic [PTR_W-1:0]      waddr,
  input  logic [ELEM_WIDTH-1:0] wdata,
  input  logic [PTR_W-1:0]      raddr,
  output logic [ELEM_WIDTH-1:0] rdata
);

  logic [ELEM_WIDTH-1:0] mem [CAPACITY];
  logic [ELEM_WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (accept && we) mem[waddr] <= wdata;
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      rdata_r <= (we && waddr == raddr) ? wdata : mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

FILE: hdl/bounded_deque_list_unit.sv
// Bounded deque list unit: top level with the read stage and the
// output register. Depends on bdl_pkg, bdl_ctrl and bdl_store.
//
// Usage:
//   Input channel (in_valid / in_stall): one word per operation, carrying
//   in_opcode, in_value and in_count. Result channel (out_valid /
//   out_stall): one word per operation with read data, length, empty flag
//   and status, in the order the operations were taken.
//   The accept edge loads the registered read port of the element store
//   and the read stage, and the output register takes the result word
//   when the read stage advances.
//   Throughput: 1 operation per cycle while in_stall is low; pointer and
//   count update in the accept cycle and a word written in that cycle is
//   bypassed to the read, so back-to-back operations on the same entry
//   need no gap. When the receiver stalls, the output word holds; one more
//   operation can sit in the read stage, after which in_stall rises.
//   Reset (rst_n low, synchronous) empties the list and drops any words in
//   flight; store contents are not cleared and are never read unless live.
module bounded_deque_list_unit
  import bdl_pkg::*;
#(
  parameter int CAPACITY   = BDL_CAPACITY,
  parameter int ELEM_WIDTH = BDL_ELEM_WIDTH,
  localparam int PTR_W = $clog2(CAPACITY),
  localparam int CNT_W = $clog2(CAPACITY + 1)
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [2:0]            in_opcode,
  input  logic [ELEM_WIDTH-1:0] in_value,
  input  logic [CNT_W-1:0]      in_count,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [ELEM_WIDTH-1:0] out_read_data,
  output logic [CNT_W-1:0]      out_list_length,
  output logic                  out_list_empty,
  output logic [1:0]            out_status
);

  logic             accept, s1_adv, out_busy;
  logic [PTR_W-1:0] waddr, raddr;
  logic [CNT_W-1:0] len_nxt;
  ctl_t             ctl;
  logic [ELEM_WIDTH-1:0] rdata;

  logic             s1_v_r;
  logic [CNT_W-1:0] s1_len_r;
  logic             s1_zero_r;
  status_t          s1_status_r;

  logic                  out_valid_r;
  logic [ELEM_WIDTH-1:0] out_data_r;
  logic [CNT_W-1:0]      out_len_r;
  logic                  out_empty_r;
  status_t               out_status_r;

  assign out_busy = out_valid_r && out_stall;
  assign s1_adv   = s1_v_r && !out_busy;
  assign in_stall = s1_v_r && out_busy;
  assign accept   = in_valid && !in_stall;

  bdl_ctrl #(
    .CAPACITY(CAPACITY)
  ) u_ctrl (
    .clk     (clk),
    .rst_n   (rst_n),
    .accept  (accept),
    .opcode  (in_opcode),
    .count   (in_count),
    .waddr   (waddr),
    .raddr   (raddr),
    .len_nxt (len_nxt),
    .ctl     (ctl)
  );

  bdl_store #(
    .CAPACITY  (CAPACITY),
    .ELEM_WIDTH(ELEM_WIDTH)
  ) u_store (
    .clk    (clk),
    .accept (accept),
    .we     (ctl.wr_en),
    .waddr  (waddr),
    .wdata  (in_value),
    .raddr  (raddr),
    .rdata  (rdata)
  );

  // read stage
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else if (accept) begin
      s1_v_r <= 1'b1;
    end else if (s1_adv) begin
      s1_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_len_r    <= len_nxt;
      s1_zero_r   <= ctl.rd_zero;
      s1_status_r <= ctl.status;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_adv) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      out_data_r   <= s1_zero_r ? '0 : rdata;
      out_len_r    <= s1_len_r;
      out_empty_r  <= (s1_len_r == '0);
      out_status_r <= s1_status_r;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_read_data   = out_data_r;
  assign out_list_length = out_len_r;
  assign out_list_empty  = out_empty_r;
  assign out_status      = out_status_r;

endmodule
